@@ design/mpst_pkg.sv @@
// Package for the motor PID controller with safety trip.
// Holds the data widths, register indexes, loop mode and status codes, and reset values.
// It has no dependencies. The core uses it through scoped names.
package mpst_pkg;

	// Sample format
	localparam int DATA_WIDTH = 24;
	localparam int FRAC_BITS  = 12;

	// Register and field widths
	localparam int GAIN_W    = 24;
	localparam int SUMLIM_W  = 39;
	localparam int SUM_W     = 40;
	localparam int MODE_W    = 2;
	localparam int STATUS_W  = 2;
	localparam int DUTY_W    = 16;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_W     = (SUMLIM_W > DATA_WIDTH) ? SUMLIM_W : DATA_WIDTH;
	localparam int IN_W      = ((4 * DATA_WIDTH + 7) / 8) * 8;
	localparam int OUT_W     = ((DUTY_W + 7) / 8) * 8;

	// Datapath widths
	localparam int ERR_W    = DATA_WIDTH + 1;
	localparam int DIFF_W   = DATA_WIDTH + 2;
	localparam int SPLIT_W  = SUM_W / 2;
	localparam int TERM_EXP = 52;
	localparam int TERM_W   = TERM_EXP + 2;
	localparam int TOT_W    = TERM_W + 1;
	localparam int MAG_W    = TOT_W - 1;

	// Drive limit of 100 percent, in Q.(FRAC_BITS+16)
	localparam logic [63:0] LIM_FULL = 64'(100) << (FRAC_BITS + 16);
	// Largest duty magnitude, 100 percent in Q8.8
	localparam int DUTY_MAX = 100 * 256;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_GAIN = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SUM_LIMIT     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_TARGET        = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_LOOP_MODE     = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_CURRENT_LIMIT = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_TEMP_LIMIT    = 3'd7;

	// Loop modes. Any other code gives zero drive.
	localparam logic [MODE_W-1:0] MODE_POS = 2'd0;
	localparam logic [MODE_W-1:0] MODE_VEL = 2'd1;

	// Status codes
	localparam logic [STATUS_W-1:0] ST_RUN      = 2'd0;
	localparam logic [STATUS_W-1:0] ST_OVERCUR  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_OVERTEMP = 2'd2;
	localparam logic [STATUS_W-1:0] ST_STOPPED  = 2'd3;

	// Register reset values
	localparam logic [GAIN_W-1:0]     RST_PROP_GAIN     = 24'd131072;
	localparam logic [GAIN_W-1:0]     RST_INTEGRAL_GAIN = 24'd328;
	localparam logic [GAIN_W-1:0]     RST_DERIV_GAIN    = 24'd655360;
	localparam logic [SUMLIM_W-1:0]   RST_SUM_LIMIT     = 39'd81920000;
	localparam logic [DATA_WIDTH-1:0] RST_TARGET        = '0;
	localparam logic [MODE_W-1:0]     RST_LOOP_MODE     = MODE_POS;
	localparam logic [DATA_WIDTH-2:0] RST_CURRENT_LIMIT = (DATA_WIDTH-1)'(40960);
	localparam logic [DATA_WIDTH-1:0] RST_TEMP_LIMIT    = DATA_WIDTH'(327680);

endpackage

@@ design/motor_pid_with_safety_trip_core.sv @@
// Motor PID controller with a latched overcurrent and overtemperature trip, as a nine-stage pipeline.
// Depends on mpst_pkg (design/mpst_pkg.sv).
// An accepted input item passes through the registered stages 1 to 9, and m_tvalid is the valid bit
// of stage 9; the result item leaves when m_tready is high.
// Throughput: one item per clock while the output side does not stall. The pipeline's stages pass
// items on without gaps. The error sum and the stop latch each update in one stage, one item per clock.
// Reset: registers return to their defaults, the error sum and previous error go to zero,
// the stop latch clears and the pipeline empties. There is no clearing pass.
module motor_pid_with_safety_trip_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// Input items
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// From bit 0 up: meas_position, meas_velocity, meas_current, meas_temperature
	input  logic [mpst_pkg::IN_W-1:0]            s_tdata,
	// Result items
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// From bit 0 up: duty
	output logic [mpst_pkg::OUT_W-1:0]           m_tdata,
	// From bit 0 up: status
	output logic [mpst_pkg::STATUS_W-1:0]        m_tuser,
	// Configuration writes
	input  logic                                 cfg_we,
	input  logic [mpst_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [mpst_pkg::CFG_W-1:0]           cfg_data
);

	localparam int DW     = mpst_pkg::DATA_WIDTH;
	localparam int FB     = mpst_pkg::FRAC_BITS;
	localparam int GW     = mpst_pkg::GAIN_W;
	localparam int NSTG   = 9;
	localparam int P_W    = GW + 1 + mpst_pkg::ERR_W;
	localparam int D_W    = GW + 1 + mpst_pkg::DIFF_W;
	localparam int IHI_W  = GW + 1 + (mpst_pkg::SUM_W - mpst_pkg::SPLIT_W);
	localparam int ILO_W  = GW + mpst_pkg::SPLIT_W;
	localparam logic signed [63:0] TERM_CAP = 64'sd1 <<< mpst_pkg::TERM_EXP;
	localparam logic [mpst_pkg::MAG_W:0] ROUND_HALF = (mpst_pkg::MAG_W + 1)'(1) << (FB + 7);

	// Saturate a product to +-2^52
	function automatic logic signed [mpst_pkg::TERM_W-1:0] sat_term(input logic signed [63:0] v);
		logic signed [mpst_pkg::TERM_W-1:0] r;
		if (v > TERM_CAP) begin
			r = mpst_pkg::TERM_W'(TERM_CAP);
		end else if (v < -TERM_CAP) begin
			r = mpst_pkg::TERM_W'(-TERM_CAP);
		end else begin
			r = mpst_pkg::TERM_W'(v);
		end
		return r;
	endfunction

	// Configuration registers
	logic [GW-1:0]                    prop_gain_q, integral_gain_q, deriv_gain_q;
	logic [mpst_pkg::SUMLIM_W-1:0]    sum_limit_q;
	logic signed [DW-1:0]             target_q, temp_limit_q;
	logic [mpst_pkg::MODE_W-1:0]      loop_mode_q;
	logic [DW-2:0]                    current_limit_q;

	// Controller state
	logic                             stop_latch_q;
	logic signed [mpst_pkg::SUM_W-1:0] error_sum_q;
	logic signed [mpst_pkg::ERR_W-1:0] last_error_q;

	// Pipeline valid bits and load enables, index k is stage k+1
	logic [NSTG-1:0] vld_q;
	logic [NSTG-1:0] rdy;

	// Stage payloads
	logic signed [DW-1:0]               pos_s1, vel_s1, cur_s1, tmp_s1;
	logic [mpst_pkg::STATUS_W-1:0]      status_s2, status_s3, status_s4, status_s5;
	logic [mpst_pkg::STATUS_W-1:0]      status_s6, status_s7, status_s8, status_s9;
	logic                               run_s2, run_s3, run_s4, run_s5, run_s6, run_s7, run_s8;
	logic signed [mpst_pkg::ERR_W-1:0]  err_s2, err_s3;
	logic signed [mpst_pkg::SUM_W-1:0]  sum_s3;
	logic signed [mpst_pkg::DIFF_W-1:0] diff_s3;
	logic signed [P_W-1:0]              pprod_s4;
	logic signed [D_W-1:0]              dprod_s4;
	logic signed [IHI_W-1:0]            ihi_s4;
	logic [ILO_W-1:0]                   ilo_s4;
	logic signed [mpst_pkg::TERM_W-1:0] pterm_s5, iterm_s5, dterm_s5;
	logic signed [mpst_pkg::TOT_W-1:0]  total_s6;
	logic                               neg_s7, neg_s8;
	logic [mpst_pkg::MAG_W-1:0]         mag_s7, magc_s8;
	logic [mpst_pkg::DUTY_W-1:0]        duty_s9;
	logic [mpst_pkg::MAG_W-1:0]         lim_q;

	// Combinational stage logic
	logic [DW-1:0]                      cur_mag;
	logic                               over_cur, over_tmp, trip;
	logic [mpst_pkg::STATUS_W-1:0]      status_c;
	logic                               run_c;
	logic signed [DW-1:0]               meas;
	logic signed [mpst_pkg::ERR_W-1:0]  err_c;
	logic signed [mpst_pkg::SUM_W:0]    sum_raw, sum_lim;
	logic signed [mpst_pkg::SUM_W-1:0]  sum_c;
	logic signed [mpst_pkg::DIFF_W-1:0] diff_c;
	logic signed [P_W-1:0]              pprod_c;
	logic signed [D_W-1:0]              dprod_c;
	logic signed [IHI_W-1:0]            ihi_c;
	logic [ILO_W-1:0]                   ilo_c;
	logic signed [63:0]                 iprod;
	logic signed [mpst_pkg::TOT_W-1:0]  total_c;
	logic [mpst_pkg::MAG_W-1:0]         mag_c, magc_c;
	logic [mpst_pkg::MAG_W:0]           rnd;
	logic [mpst_pkg::DUTY_W-1:0]        rmag, duty_c;
	logic [63:0]                        cap, lim_c;

	// Load enables: a stage loads when it is empty or its item moves on
	always_comb begin
		rdy[NSTG-1] = !vld_q[NSTG-1] || m_tready;
		for (int k = NSTG - 2; k >= 0; k--) begin
			rdy[k] = !vld_q[k] || rdy[k+1];
		end
	end

	assign s_tready = rdy[0];
	assign m_tvalid = vld_q[NSTG-1];
	assign m_tdata  = mpst_pkg::OUT_W'(duty_s9);
	assign m_tuser  = status_s9;

	// Stage 1: trip checks, status and error
	always_comb begin
		cur_mag  = cur_s1[DW-1] ? DW'(-cur_s1) : DW'(cur_s1);
		over_cur = cur_mag > {1'b0, current_limit_q};
		over_tmp = tmp_s1 > temp_limit_q;
		trip     = over_cur || over_tmp;
		if (over_cur) begin
			status_c = mpst_pkg::ST_OVERCUR;
		end else if (over_tmp) begin
			status_c = mpst_pkg::ST_OVERTEMP;
		end else if (stop_latch_q) begin
			status_c = mpst_pkg::ST_STOPPED;
		end else begin
			status_c = mpst_pkg::ST_RUN;
		end
		run_c = (status_c == mpst_pkg::ST_RUN) &&
			((loop_mode_q == mpst_pkg::MODE_POS) || (loop_mode_q == mpst_pkg::MODE_VEL));
		meas  = (loop_mode_q == mpst_pkg::MODE_VEL) ? vel_s1 : pos_s1;
		err_c = mpst_pkg::ERR_W'(target_q) - mpst_pkg::ERR_W'(meas);
	end

	// Stage 2: clamped error sum and error difference
	always_comb begin
		sum_lim = $signed({2'b00, sum_limit_q});
		sum_raw = (mpst_pkg::SUM_W + 1)'(error_sum_q) + (mpst_pkg::SUM_W + 1)'(err_s2);
		if (sum_raw > sum_lim) begin
			sum_c = mpst_pkg::SUM_W'(sum_lim);
		end else if (sum_raw < -sum_lim) begin
			sum_c = mpst_pkg::SUM_W'(-sum_lim);
		end else begin
			sum_c = mpst_pkg::SUM_W'(sum_raw);
		end
		diff_c = mpst_pkg::DIFF_W'(err_s2) - mpst_pkg::DIFF_W'(last_error_q);
	end

	// Stage 3: gain products, the integral one split in two halves
	assign pprod_c = $signed({1'b0, prop_gain_q}) * err_s3;
	assign dprod_c = $signed({1'b0, deriv_gain_q}) * diff_s3;
	assign ihi_c   = $signed({1'b0, integral_gain_q}) *
		$signed(sum_s3[mpst_pkg::SUM_W-1:mpst_pkg::SPLIT_W]);
	assign ilo_c   = integral_gain_q * sum_s3[mpst_pkg::SPLIT_W-1:0];

	// Stage 4: join the integral halves
	assign iprod = ($signed(64'(ihi_s4)) <<< mpst_pkg::SPLIT_W) + $signed(64'(ilo_s4));

	// Stage 5: sum of the three terms
	assign total_c = mpst_pkg::TOT_W'(pterm_s5) + mpst_pkg::TOT_W'(iterm_s5) +
		mpst_pkg::TOT_W'(dterm_s5);

	// Stage 6: magnitude
	assign mag_c = total_s6[mpst_pkg::TOT_W-1] ? mpst_pkg::MAG_W'(-total_s6) :
		mpst_pkg::MAG_W'(total_s6);

	// Drive limit: the smaller of 100 percent and 10 x current_limit
	always_comb begin
		cap   = ((64'(current_limit_q) << 3) + (64'(current_limit_q) << 1)) << 16;
		lim_c = (cap < mpst_pkg::LIM_FULL) ? cap : mpst_pkg::LIM_FULL;
	end

	// Stage 7: magnitude clamp
	assign magc_c = (mag_s7 > lim_q) ? lim_q : mag_s7;

	// Stage 8: round half away from zero to Q8.8, restore the sign, and zero the duty of items that do not run
	always_comb begin
		rnd    = (mpst_pkg::MAG_W + 1)'(magc_s8) + ROUND_HALF;
		rmag   = mpst_pkg::DUTY_W'(rnd >> (FB + 8));
		duty_c = neg_s8 ? -rmag : rmag;
		if (!run_s8) begin
			duty_c = '0;
		end
	end

	// Control state: valid bits, configuration, latch and PID state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q           <= '0;
			prop_gain_q     <= mpst_pkg::RST_PROP_GAIN;
			integral_gain_q <= mpst_pkg::RST_INTEGRAL_GAIN;
			deriv_gain_q    <= mpst_pkg::RST_DERIV_GAIN;
			sum_limit_q     <= mpst_pkg::RST_SUM_LIMIT;
			target_q        <= mpst_pkg::RST_TARGET;
			loop_mode_q     <= mpst_pkg::RST_LOOP_MODE;
			current_limit_q <= mpst_pkg::RST_CURRENT_LIMIT;
			temp_limit_q    <= mpst_pkg::RST_TEMP_LIMIT;
			stop_latch_q    <= 1'b0;
			error_sum_q     <= '0;
			last_error_q    <= '0;
		end else begin
			if (rdy[0]) begin
				vld_q[0] <= s_tvalid;
			end
			for (int k = 1; k < NSTG; k++) begin
				if (rdy[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
			if (cfg_we) begin
				unique case (cfg_index)
					mpst_pkg::REG_PROP_GAIN:     prop_gain_q     <= cfg_data[GW-1:0];
					mpst_pkg::REG_INTEGRAL_GAIN: integral_gain_q <= cfg_data[GW-1:0];
					mpst_pkg::REG_DERIV_GAIN:    deriv_gain_q    <= cfg_data[GW-1:0];
					mpst_pkg::REG_SUM_LIMIT:     sum_limit_q     <= cfg_data[mpst_pkg::SUMLIM_W-1:0];
					mpst_pkg::REG_TARGET:        target_q        <= cfg_data[DW-1:0];
					mpst_pkg::REG_LOOP_MODE:     loop_mode_q     <= cfg_data[mpst_pkg::MODE_W-1:0];
					mpst_pkg::REG_CURRENT_LIMIT: current_limit_q <= cfg_data[DW-2:0];
					mpst_pkg::REG_TEMP_LIMIT:    temp_limit_q    <= cfg_data[DW-1:0];
					default: ;
				endcase
			end
			// Latch sets on a trip as the item leaves stage 1
			if (rdy[1] && vld_q[0] && trip) begin
				stop_latch_q <= 1'b1;
			end
			// PID state moves only for running items, frozen otherwise
			if (rdy[2] && vld_q[1] && run_s2) begin
				error_sum_q  <= sum_c;
				last_error_q <= err_s2;
			end
		end
	end

	// Stage payloads
	always_ff @(posedge clk) begin
		lim_q <= mpst_pkg::MAG_W'(lim_c);
		if (rdy[0]) begin
			pos_s1 <= s_tdata[DW-1:0];
			vel_s1 <= s_tdata[2*DW-1:DW];
			cur_s1 <= s_tdata[3*DW-1:2*DW];
			tmp_s1 <= s_tdata[4*DW-1:3*DW];
		end
		if (rdy[1]) begin
			status_s2 <= status_c;
			run_s2    <= run_c;
			err_s2    <= err_c;
		end
		if (rdy[2]) begin
			status_s3 <= status_s2;
			run_s3    <= run_s2;
			err_s3    <= err_s2;
			sum_s3    <= sum_c;
			diff_s3   <= diff_c;
		end
		if (rdy[3]) begin
			status_s4 <= status_s3;
			run_s4    <= run_s3;
			pprod_s4  <= pprod_c;
			dprod_s4  <= dprod_c;
			ihi_s4    <= ihi_c;
			ilo_s4    <= ilo_c;
		end
		if (rdy[4]) begin
			status_s5 <= status_s4;
			run_s5    <= run_s4;
			pterm_s5  <= sat_term(64'(pprod_s4));
			iterm_s5  <= sat_term(iprod);
			dterm_s5  <= sat_term(64'(dprod_s4));
		end
		if (rdy[5]) begin
			status_s6 <= status_s5;
			run_s6    <= run_s5;
			total_s6  <= total_c;
		end
		if (rdy[6]) begin
			status_s7 <= status_s6;
			run_s7    <= run_s6;
			neg_s7    <= total_s6[mpst_pkg::TOT_W-1];
			mag_s7    <= mag_c;
		end
		if (rdy[7]) begin
			status_s8 <= status_s7;
			run_s8    <= run_s7;
			neg_s8    <= neg_s7;
			magc_s8   <= magc_c;
		end
		if (rdy[8]) begin
			status_s9 <= status_s8;
			duty_s9   <= duty_c;
		end
	end

	// Checks
	// A stopped or tripped result carries zero drive
	a_stop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tuser != mpst_pkg::ST_RUN)) |-> (duty_s9 == '0))
		else $error("nonzero duty on a stopped result");

	// Duty never leaves +-100 percent
	a_duty_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (($signed(duty_s9) <= mpst_pkg::DUTY_MAX) &&
			($signed(duty_s9) >= -mpst_pkg::DUTY_MAX)))
		else $error("duty out of range");

	// Only reset releases the stop latch
	a_latch_holds: assert property (@(posedge clk) disable iff (!arst_n)
		stop_latch_q |=> stop_latch_q)
		else $error("stop latch released");

	// A stopped-earlier status needs the latch
	a_stopped_latch: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tuser == mpst_pkg::ST_STOPPED)) |-> stop_latch_q)
		else $error("stopped status without latch");

endmodule
